FILE: design/btnar_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the button auto-repeat front end.
// No dependencies; imported by button_autorepeat_sequence_frontend_top.
package btnar_pkg;

    localparam int NUM_BUTTONS = 8;
    localparam int CODE_W      = 4;
    localparam int CFG_REG_W   = 16;
    localparam int IDLE_W      = 32;
    localparam int DELTA_W     = 10;

    // input word kinds
    localparam logic [1:0] KIND_TICK      = 2'd0;
    localparam logic [1:0] KIND_CLEAR     = 2'd1;
    localparam logic [1:0] KIND_HIST_CLR  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_HOLD_THRESH = 2'd0;
    localparam logic [1:0] CFG_REP_PERIOD  = 2'd1;
    localparam logic [1:0] CFG_REP_DELAY   = 2'd2;
    localparam logic [1:0] CFG_SPELL_SEQ   = 2'd3;

    localparam logic [CFG_REG_W-1:0] HOLD_THRESH_RST = 16'd500;
    localparam logic [CFG_REG_W-1:0] REP_PERIOD_RST  = 16'd100;
    localparam logic [CFG_REG_W-1:0] REP_DELAY_RST   = 16'd150;
    localparam int                   REP_DELAY_BASE  = 5;

    // history code that marks an empty slot
    localparam logic [CODE_W-1:0] CODE_EMPTY = CODE_W'(NUM_BUTTONS);

    typedef struct packed {
        logic [1:0]             kind;
        logic [NUM_BUTTONS-1:0] raw_buttons;
        logic                   screen_flipped;
        logic                   touch_active;
        logic [DELTA_W-1:0]     delta_ms;
    } t_in_word;

    typedef struct packed {
        logic [NUM_BUTTONS-1:0] pressed_mask;
        logic [NUM_BUTTONS-1:0] released_mask;
        logic [NUM_BUTTONS-1:0] held_mask;
        logic [NUM_BUTTONS-1:0] pulse_mask;
        logic                   spell_match;
        logic [IDLE_W-1:0]      idle_ms;
    } t_out_word;

endpackage

FILE: design/button_autorepeat_sequence_frontend_top.sv
`timescale 1ns / 1ps
// Button front end: edge detect, hold/repeat timers, press history match, idle timer.
// Depends on btnar_pkg for the word types, kinds and register indexes.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in) carries one word per frame tick,
//   clear-and-suppress command or history-clear command. Every word yields exactly
//   one output word on o_out_valid / i_out_ready / o_out, describing the button
//   state after the word is applied.
//   Configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data) is
//   always ready; write it only while no word is in flight.
//   An accepted word is captured in the input register, processed in one combinational
//   pass and lands in the output register, which drives o_out_valid.
//   Throughput: one word per cycle while i_out_ready stays high; the input and output
//   registers form a two-stage pipeline, and the single pass over the 8 button lanes
//   and the history shift line sets the cycle.
//   Stall: when the receiver holds i_out_ready low, the output word holds, one more
//   word waits in the input register, then o_in_ready drops.
//   Reset: all timers and masks clear, the history fills with empty codes and the
//   registers return to their defaults; no words are in flight.
module button_autorepeat_sequence_frontend_top
    import btnar_pkg::*;
#(
    parameter int HISTORY_DEPTH = 10,
    parameter int TIME_WIDTH    = 16,
    localparam int SEQ_W  = CODE_W * HISTORY_DEPTH,
    localparam int CFG_DW = (SEQ_W > CFG_REG_W) ? SEQ_W : CFG_REG_W
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_word          i_in,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_word         o_out,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [CFG_DW-1:0] i_cfg_data
);

    localparam int SW = ((TIME_WIDTH > CFG_REG_W) ? TIME_WIDTH : CFG_REG_W) + 1;
    localparam logic [TIME_WIDTH-1:0]  TIME_MAX  = '1;
    localparam logic [SEQ_W-1:0]       SEQ_RST   = {HISTORY_DEPTH{CODE_EMPTY}};
    localparam logic [NUM_BUTTONS-1:0] ALL_BTNS  = '1;

    // configuration
    logic [CFG_REG_W-1:0] r_hold_thresh;
    logic [CFG_REG_W-1:0] r_rep_period;
    logic [CFG_REG_W-1:0] r_rep_delay;
    logic [SEQ_W-1:0]     r_spell_seq;

    // pipeline
    logic      r_in_valid;
    t_in_word  r_in;
    logic      r_out_valid;
    t_out_word r_out;
    logic      w_advance;

    // button state
    logic [NUM_BUTTONS-1:0] r_down_now, n_down_now;
    logic [NUM_BUTTONS-1:0] r_down_before, n_down_before;
    logic [NUM_BUTTONS-1:0] r_supp, n_supp;
    logic [TIME_WIDTH-1:0]  r_hold [NUM_BUTTONS];
    logic [TIME_WIDTH-1:0]  n_hold [NUM_BUTTONS];
    logic [TIME_WIDTH-1:0]  r_phase [NUM_BUTTONS];
    logic [TIME_WIDTH-1:0]  n_phase [NUM_BUTTONS];
    logic [CODE_W-1:0]      r_hist [HISTORY_DEPTH];
    logic [CODE_W-1:0]      n_hist [HISTORY_DEPTH];
    logic [IDLE_W-1:0]      r_idle, n_idle;
    t_out_word              n_out;

    assign o_cfg_ready = 1'b1;
    assign w_advance   = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_advance;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // next state and result in one pass
    always_comb begin
        logic [NUM_BUTTONS-1:0] m;
        logic [NUM_BUTTONS-1:0] new_press;
        logic [SW-1:0]          h_sum;
        logic [SW-1:0]          p_sum;
        logic [SW-1:0]          delay;
        logic [SW-1:0]          delay_min;
        logic [IDLE_W:0]        idle_sum;
        logic                   match;

        n_down_now    = r_down_now;
        n_down_before = r_down_before;
        n_supp        = r_supp;
        n_idle        = r_idle;
        n_hold        = r_hold;
        n_phase       = r_phase;
        n_hist        = r_hist;
        new_press     = '0;
        h_sum         = '0;
        p_sum         = '0;
        idle_sum      = '0;

        // flip swaps each adjacent pair of buttons
        m = r_in.raw_buttons;
        if (r_in.screen_flipped) begin
            for (int k = 0; k < NUM_BUTTONS / 2; k++) begin
                m[2*k]   = r_in.raw_buttons[2*k+1];
                m[2*k+1] = r_in.raw_buttons[2*k];
            end
        end

        case (r_in.kind)
            KIND_TICK: begin
                n_supp        = r_supp & m;
                n_down_before = r_down_now;
                n_down_now    = m & ~n_supp;
                new_press     = n_down_now & ~r_down_now;
                for (int i = 0; i < NUM_BUTTONS; i++) begin
                    h_sum = SW'(r_hold[i]) + SW'(r_in.delta_ms);
                    p_sum = SW'(r_phase[i]) + SW'(r_in.delta_ms);
                    if (!n_down_now[i]) begin
                        n_hold[i]  = '0;
                        n_phase[i] = '0;
                    end else begin
                        n_hold[i] = (h_sum > SW'(TIME_MAX)) ? TIME_MAX
                                                            : h_sum[TIME_WIDTH-1:0];
                        if (p_sum >= SW'(r_rep_period)) begin
                            n_phase[i] = '0;
                        end else if (p_sum > SW'(TIME_MAX)) begin
                            n_phase[i] = TIME_MAX;
                        end else begin
                            n_phase[i] = p_sum[TIME_WIDTH-1:0];
                        end
                    end
                    // shift in presses in ascending button order, newest at slot 0
                    if (new_press[i]) begin
                        for (int j = HISTORY_DEPTH - 1; j > 0; j--) begin
                            n_hist[j] = n_hist[j-1];
                        end
                        n_hist[0] = CODE_W'(i);
                    end
                end
                idle_sum = {1'b0, r_idle} + (IDLE_W + 1)'(r_in.delta_ms);
                if (m != '0 || r_in.touch_active) begin
                    n_idle = '0;
                end else if (idle_sum[IDLE_W]) begin
                    n_idle = '1;
                end else begin
                    n_idle = idle_sum[IDLE_W-1:0];
                end
            end
            KIND_CLEAR: begin
                n_down_now = '0;
                n_supp     = ALL_BTNS;
            end
            KIND_HIST_CLR: begin
                for (int j = 0; j < HISTORY_DEPTH; j++) begin
                    n_hist[j] = CODE_EMPTY;
                end
            end
            default: begin
            end
        endcase

        delay_min = SW'(r_rep_delay);
        delay     = SW'({r_in.delta_ms, 1'b0}) + SW'(REP_DELAY_BASE);
        if (delay < delay_min) begin
            delay = delay_min;
        end

        n_out.pressed_mask  = n_down_now & ~n_down_before;
        n_out.released_mask = n_down_before & ~n_down_now;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            n_out.held_mask[i]  = n_down_now[i] && (SW'(n_hold[i]) >= SW'(r_hold_thresh));
            if (SW'(n_hold[i]) < delay) begin
                n_out.pulse_mask[i] = n_down_now[i] && !n_down_before[i];
            end else begin
                n_out.pulse_mask[i] = n_down_now[i] && (n_phase[i] == '0);
            end
        end

        // newest slot pairs with the last sequence entry
        match = 1'b1;
        for (int s = 0; s < HISTORY_DEPTH; s++) begin
            if (n_hist[s] != r_spell_seq[CODE_W*(HISTORY_DEPTH-1-s) +: CODE_W]) begin
                match = 1'b0;
            end
        end
        n_out.spell_match = match;
        n_out.idle_ms     = n_idle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_hold_thresh <= HOLD_THRESH_RST;
            r_rep_period  <= REP_PERIOD_RST;
            r_rep_delay   <= REP_DELAY_RST;
            r_spell_seq   <= SEQ_RST;
            r_down_now    <= '0;
            r_down_before <= '0;
            r_supp        <= '0;
            r_idle        <= '0;
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                r_hold[i]  <= '0;
                r_phase[i] <= '0;
            end
            for (int j = 0; j < HISTORY_DEPTH; j++) begin
                r_hist[j] <= CODE_EMPTY;
            end
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_out_valid   <= 1'b1;
                r_down_now    <= n_down_now;
                r_down_before <= n_down_before;
                r_supp        <= n_supp;
                r_idle        <= n_idle;
                r_hold        <= n_hold;
                r_phase       <= n_phase;
                r_hist        <= n_hist;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_HOLD_THRESH: r_hold_thresh <= i_cfg_data[CFG_REG_W-1:0];
                    CFG_REP_PERIOD:  r_rep_period  <= i_cfg_data[CFG_REG_W-1:0];
                    CFG_REP_DELAY:   r_rep_delay   <= i_cfg_data[CFG_REG_W-1:0];
                    CFG_SPELL_SEQ:   r_spell_seq   <= i_cfg_data[SEQ_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
        if (w_advance) begin
            r_out <= n_out;
        end
    end

    a_down_not_supp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_down_now & r_supp) == '0)
        else $error("suppressed button reported down");

    a_edges_disjoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.pressed_mask & o_out.released_mask) == '0)
        else $error("button both pressed and released");

    a_released_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out.held_mask | o_out.pulse_mask) & o_out.released_mask) == '0)
        else $error("released button reported held or pulsing");

    a_clear_effect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in.kind == KIND_CLEAR) |=> (r_down_now == '0 && r_supp == ALL_BTNS))
        else $error("clear word left buttons down or unsuppressed");

    a_advance_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> o_out_valid)
        else $error("processed word did not reach the output register");

endmodule
